>>> rtl/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

  // Input op codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_NACK  = 2'd1;
  localparam logic [1:0] OP_SHORT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_CONN  = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_TMP_BIAS = 2'd0;
  localparam logic [1:0] REG_TMP_SPAN = 2'd1;
  localparam logic [1:0] REG_RH_SPAN  = 2'd2;

  // Configuration reset values
  localparam logic signed [15:0] TMP_BIAS_RST = -16'sd4500;
  localparam logic [15:0]        TMP_SPAN_RST = 16'd17500;
  localparam logic [15:0]        RH_SPAN_RST  = 16'd10000;

  // Frame result handed from the frame tracker to the converter
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
  } frm_t;

endpackage

>>> rtl/scc_frame.sv
`timescale 1ns / 1ps

module scc_frame (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    op,
  input  logic [7:0]    rx_byte,
  output logic          frm_valid,
  output scc_pkg::frm_t frm,
  input  logic          frm_ready
);
  import scc_pkg::*;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // CRC-8, poly 0x31, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] temp_word, temp_word_next;
  logic [15:0] hum_word, hum_word_next;
  logic        crc_failed, crc_failed_next;
  logic        emit;
  frm_t        res;
  logic        accept;
  logic [7:0]  crc_upd;
  logic        bad;

  assign in_ready = !frm_valid || frm_ready;
  assign accept   = in_valid && in_ready;
  assign crc_upd  = crc8_byte(running_crc, rx_byte);
  assign bad      = crc_failed || (running_crc != rx_byte);

  // Frame sequencing
  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    temp_word_next     = temp_word;
    hum_word_next      = hum_word;
    crc_failed_next    = crc_failed;
    emit               = 1'b0;
    res                = '0;
    case (op)
      OP_NACK: begin
        emit       = 1'b1;
        res.status = ST_NO_CONN;
      end
      OP_SHORT: begin
        emit       = 1'b1;
        res.status = ST_TIMEOUT;
      end
      OP_BYTE: begin
        case (byte_position)
          3'd0: begin
            running_crc_next   = crc_upd;
            temp_word_next     = {rx_byte, 8'h00};
            byte_position_next = 3'd1;
          end
          3'd1: begin
            running_crc_next   = crc_upd;
            temp_word_next     = {temp_word[15:8], rx_byte};
            byte_position_next = 3'd2;
          end
          3'd2: begin
            if (running_crc != rx_byte) crc_failed_next = 1'b1;
            running_crc_next   = CRC_INIT;
            byte_position_next = 3'd3;
          end
          3'd3: begin
            running_crc_next   = crc_upd;
            hum_word_next      = {rx_byte, 8'h00};
            byte_position_next = 3'd4;
          end
          3'd4: begin
            running_crc_next   = crc_upd;
            hum_word_next      = {hum_word[15:8], rx_byte};
            byte_position_next = 3'd5;
          end
          default: begin
            // sixth byte: humidity CRC, close the frame
            emit = 1'b1;
            if (bad) begin
              res.status = ST_CRC_ERR;
            end else begin
              res.status   = ST_OK;
              res.raw_temp = temp_word;
              res.raw_hum  = hum_word;
            end
          end
        endcase
      end
      default: ;  // unused op: no effect
    endcase
    // any result restarts the frame
    if (emit) begin
      byte_position_next = '0;
      running_crc_next   = CRC_INIT;
      temp_word_next     = '0;
      hum_word_next      = '0;
      crc_failed_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= CRC_INIT;
      temp_word     <= '0;
      hum_word      <= '0;
      crc_failed    <= 1'b0;
      frm_valid     <= 1'b0;
    end else begin
      if (accept) begin
        byte_position <= byte_position_next;
        running_crc   <= running_crc_next;
        temp_word     <= temp_word_next;
        hum_word      <= hum_word_next;
        crc_failed    <= crc_failed_next;
      end
      if (accept && emit) begin
        frm_valid <= 1'b1;
      end else if (frm_ready) begin
        frm_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && emit) frm <= res;
  end

endmodule

>>> rtl/scc_conv.sv
`timescale 1ns / 1ps

module scc_conv (
  input  logic               clk,
  input  logic               rst,
  input  logic               frm_valid,
  input  scc_pkg::frm_t      frm,
  output logic               frm_ready,
  input  logic signed [15:0] tmp_bias,
  input  logic [15:0]        tmp_span,
  input  logic [15:0]        rh_span,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [15:0]        raw_temp,
  output logic [15:0]        raw_hum,
  output logic signed [15:0] temp_hundredths,
  output logic [15:0]        hum_hundredths
);
  import scc_pkg::*;

  localparam logic signed [17:0] TEMP_MAX = 18'sd32767;

  // floor(p / 65535) for p < 2^32; quotient fits 16 bits here
  function automatic logic [15:0] div_fs(input logic [31:0] p);
    logic [32:0] s;
    s = {1'b0, p} + {17'b0, p[31:16]} + 33'd1;
    return s[31:16];
  endfunction

  logic        prod_valid;
  frm_t        prod_frm;
  logic [31:0] prod_temp;
  logic [31:0] prod_hum;
  logic        prod_ready;
  logic        prod_load;
  logic        out_load;
  logic [15:0] q_temp;
  logic [15:0] q_hum;
  logic signed [17:0] temp_sum;
  logic signed [15:0] temp_sat;

  assign prod_ready = !out_valid || out_ready;
  assign frm_ready  = !prod_valid || prod_ready;
  assign prod_load  = frm_valid && frm_ready;
  assign out_load   = prod_valid && prod_ready;

  // Stage 1: scale products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (frm_ready) begin
      prod_valid <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_load) begin
      prod_frm  <= frm;
      prod_temp <= {16'b0, tmp_span} * {16'b0, frm.raw_temp};
      prod_hum  <= {16'b0, rh_span} * {16'b0, frm.raw_hum};
    end
  end

  // Stage 2: divide by full scale, add offset, saturate high side
  // (offset >= -32768 and quotient >= 0, so the low side cannot clip)
  assign q_temp   = div_fs(prod_temp);
  assign q_hum    = div_fs(prod_hum);
  assign temp_sum = 18'(tmp_bias) + $signed({2'b00, q_temp});
  assign temp_sat = (temp_sum > TEMP_MAX) ? 16'sh7FFF : temp_sum[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= prod_frm.status;
      if (prod_frm.status == ST_OK) begin
        raw_temp        <= prod_frm.raw_temp;
        raw_hum         <= prod_frm.raw_hum;
        temp_hundredths <= temp_sat;
        hum_hundredths  <= q_hum;
      end else begin
        raw_temp        <= '0;
        raw_hum         <= '0;
        temp_hundredths <= '0;
        hum_hundredths  <= '0;
      end
    end
  end

endmodule

>>> rtl/sensor_frame_crc_check_convert.sv
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// -------  ----------------------  -----------------------------------------
// input    in_valid / in_ready     op, rx_byte
// output   out_valid / out_ready   status, raw_temp, raw_hum,
//                                  temp_hundredths, hum_hundredths
// config   cfg_wr_en               cfg_index, cfg_data
//
// One input beat per cycle while in_ready is high; the CRC and frame state update
// at the edge that accepts the beat. A closing beat loads the frame register at that
// edge, then the product register (two 16x16 multipliers), then the output register
// (divide/offset/saturate); out_valid rises when the output register loads.
// Synchronous reset clears control state and loads the register defaults.
// Output stalls back up through the stages; in_ready drops only once all
// three stages hold a result and out_ready is low.

module sensor_frame_crc_check_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [15:0]        raw_temp,
  output logic [15:0]        raw_hum,
  output logic signed [15:0] temp_hundredths,
  output logic [15:0]        hum_hundredths
);
  import scc_pkg::*;

  logic signed [15:0] tmp_bias;
  logic [15:0]        tmp_span;
  logic [15:0]        rh_span;
  logic               frm_valid;
  logic               frm_ready;
  frm_t               frm;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tmp_bias <= TMP_BIAS_RST;
      tmp_span <= TMP_SPAN_RST;
      rh_span  <= RH_SPAN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TMP_BIAS: tmp_bias <= $signed(cfg_data);
        REG_TMP_SPAN: tmp_span <= cfg_data;
        REG_RH_SPAN:  rh_span  <= cfg_data;
        default: ;
      endcase
    end
  end

  scc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .rx_byte   (rx_byte),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready)
  );

  scc_conv u_conv (
    .clk             (clk),
    .rst             (rst),
    .frm_valid       (frm_valid),
    .frm             (frm),
    .frm_ready       (frm_ready),
    .tmp_bias        (tmp_bias),
    .tmp_span        (tmp_span),
    .rh_span         (rh_span),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .raw_temp        (raw_temp),
    .raw_hum         (raw_hum),
    .temp_hundredths (temp_hundredths),
    .hum_hundredths  (hum_hundredths)
  );

endmodule

>>> verif/sensor_frame_crc_check_convert_test.sv
`timescale 1ns / 1ps

module sensor_frame_crc_check_convert_test;
  import scc_pkg::*;

  // Codes the package leaves out
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [7:0] CRC_POLY      = 8'h31;
  localparam logic [7:0] CRC_SEED      = 8'hFF;
  localparam longint     FULL_SCALE    = 65535;
  localparam int         FRAME_BYTES   = 6;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         RANDOM_PHASES = 6;
  localparam int         PHASE_BEATS   = 212;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    logic [15:0] temp_h;
    logic [15:0] hum_h;
  } reading_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         op        = OP_BYTE;
  logic [7:0]         rx_byte   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [15:0]        raw_temp;
  logic [15:0]        raw_hum;
  logic signed [15:0] temp_hundredths;
  logic [15:0]        hum_hundredths;

  sensor_frame_crc_check_convert u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .raw_temp        (raw_temp),
    .raw_hum         (raw_hum),
    .temp_hundredths (temp_hundredths),
    .hum_hundredths  (hum_hundredths)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the conversion registers
  logic signed [15:0] cfg_tmp_bias = TMP_BIAS_RST;
  logic [15:0]        cfg_tmp_span = TMP_SPAN_RST;
  logic [15:0]        cfg_rh_span  = RH_SPAN_RST;

  // Predictor copy of the frame tracker
  logic [2:0]  frame_pos  = '0;
  logic [7:0]  frame_crc  = CRC_SEED;
  logic [15:0] temp_word  = '0;
  logic [7:0]  hum_hi     = '0;
  logic [7:0]  hum_lo     = '0;
  logic        crc_bad    = 1'b0;

  reading_t expected_readings[$];
  int       errors     = 0;
  int       beats_sent = 0;
  int       gap_pct    = 30;
  int       stall_pct  = 30;
  int       sink_hold  = 0;

  // CRC-8, poly 0x31, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    int         k;
    c = crc ^ b;
    for (k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [15:0] w);
    return crc8_step(crc8_step(CRC_SEED, w[15:8]), w[7:0]);
  endfunction

  // floor(offset + scale*raw/65535), saturated to 16 bits signed
  function automatic logic [15:0] scale_temp(input logic [15:0] raw);
    longint num;
    longint q;
    num = longint'(cfg_tmp_bias) * FULL_SCALE
        + longint'(cfg_tmp_span) * longint'(raw);
    q = num / FULL_SCALE;
    if ((num % FULL_SCALE) != 0 && num < 0) q = q - 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [15:0] scale_hum(input logic [15:0] raw);
    longint p;
    p = longint'(cfg_rh_span) * longint'(raw);
    return 16'(p / FULL_SCALE);
  endfunction

  function automatic int idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic restart_frame();
    frame_pos = '0;
    frame_crc = CRC_SEED;
    temp_word = '0;
    hum_hi    = '0;
    hum_lo    = '0;
    crc_bad   = 1'b0;
  endtask

  // Advance the frame tracker by one accepted beat; queue any reading it closes
  task automatic track_frame_beat(input logic [1:0] beat_op, input logic [7:0] b);
    reading_t r;
    logic     bad;
    logic [15:0] rh;
    r = '0;
    case (beat_op)
      OP_NACK: begin
        restart_frame();
        r.status = ST_NO_CONN;
        expected_readings.push_back(r);
      end
      OP_SHORT: begin
        restart_frame();
        r.status = ST_TIMEOUT;
        expected_readings.push_back(r);
      end
      OP_BYTE: begin
        case (frame_pos)
          3'd0: begin
            frame_crc = crc8_step(frame_crc, b);
            temp_word = {b, 8'h00};
            frame_pos = 3'd1;
          end
          3'd1: begin
            frame_crc      = crc8_step(frame_crc, b);
            temp_word[7:0] = b;
            frame_pos      = 3'd2;
          end
          3'd2: begin
            if (frame_crc != b) crc_bad = 1'b1;
            frame_crc = CRC_SEED;
            frame_pos = 3'd3;
          end
          3'd3: begin
            frame_crc = crc8_step(frame_crc, b);
            hum_hi    = b;
            frame_pos = 3'd4;
          end
          3'd4: begin
            frame_crc = crc8_step(frame_crc, b);
            hum_lo    = b;
            frame_pos = 3'd5;
          end
          default: begin
            // closing byte: check humidity CRC and convert
            bad = crc_bad || (frame_crc != b);
            rh  = {hum_hi, hum_lo};
            if (bad) begin
              r.status = ST_CRC_ERR;
            end else begin
              r.status   = ST_OK;
              r.raw_temp = temp_word;
              r.raw_hum  = rh;
              r.temp_h   = scale_temp(temp_word);
              r.hum_h    = scale_hum(rh);
            end
            expected_readings.push_back(r);
            restart_frame();
          end
        endcase
      end
      default: ; // unused op: no effect
    endcase
  endtask

  // Send one beat after a random gap; returns at the falling edge after acceptance
  task automatic send_beat(input logic [1:0] beat_op, input logic [7:0] b);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op       = beat_op;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    track_frame_beat(beat_op, b);
    if (beat_op != OP_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  // Six-byte frame; bad_crc[0] spoils the temperature CRC, bad_crc[1] the humidity CRC.
  // An unused-op beat goes in before byte ignore_at when that is in range.
  task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                            input logic [1:0] bad_crc, input int ignore_at);
    logic [7:0] fb[FRAME_BYTES];
    int         i;
    fb = '{t[15:8], t[7:0], crc8_word(t), h[15:8], h[7:0], crc8_word(h)};
    if (bad_crc[0]) fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
    if (bad_crc[1]) fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
    for (i = 0; i < FRAME_BYTES; i++) begin
      if (i == ignore_at) send_beat(OP_UNUSED, 8'($urandom));
      send_beat(OP_BYTE, fb[i]);
    end
  endtask

  // Hold off until every reading is out and the pipeline has settled
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_TMP_BIAS: cfg_tmp_bias = data;
      REG_TMP_SPAN: cfg_tmp_span = data;
      REG_RH_SPAN:  cfg_rh_span  = data;
      default: ;
    endcase
  endtask

  task automatic write_conversion(input logic [15:0] offset, input logic [15:0] tscale,
                                  input logic [15:0] hscale);
    write_reg(REG_TMP_BIAS, offset);
    write_reg(REG_TMP_SPAN, tscale);
    write_reg(REG_RH_SPAN, hscale);
  endtask

  // Reset defaults: word extremes, error events, CRC mismatches
  task automatic test_frame_events();
    send_frame(16'hFFFF, 16'h0000, 2'b00, 3);
    send_frame(16'h0000, 16'hFFFF, 2'b00, -1);
    // restart mid-frame on a NACK, then a short read after one byte
    send_beat(OP_BYTE, 8'hBE);
    send_beat(OP_BYTE, 8'hEF);
    send_beat(OP_NACK, 8'h00);
    send_beat(OP_BYTE, 8'h12);
    send_beat(OP_SHORT, 8'hFF);
    send_frame(16'h1234, 16'hABCD, 2'b01, -1);
    send_frame(16'h6666, 16'h8000, 2'b10, -1);
  endtask

  // Register extremes: high-side saturation, zero spans, negative floor
  task automatic test_conversion_extremes();
    write_conversion(16'h7FFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF, 2'b00, -1);
    send_frame(16'h8000, 16'h0001, 2'b00, -1);
    write_conversion(16'h8000, 16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF, 2'b00, -1);
    write_conversion(16'hFFFF, 16'h0003, 16'h0001);
    send_frame(16'h0001, 16'hFFFE, 2'b00, -1);
    send_frame(16'h5555, 16'hFFFF, 2'b00, -1);
    write_conversion(16'h8000, 16'hFFFF, 16'h7FFF);
    send_frame(16'h0000, 16'hFFFF, 2'b00, -1);
    send_frame(16'hFFFF, 16'h0001, 2'b00, -1);
  endtask

  task automatic send_random_unit();
    int pick;
    int n;
    int i;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_frame(rand_word(), rand_word(),
                 ($urandom_range(9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00,
                 ($urandom_range(9) == 0) ? $urandom_range(0, 5) : -1);
    end else if (pick < 85) begin
      // truncated frame ended by an error event
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) send_beat(OP_BYTE, 8'($urandom));
      send_beat($urandom_range(1) ? OP_NACK : OP_SHORT, 8'($urandom));
    end else if (pick < 95) begin
      send_beat(2'($urandom_range(0, 3)), 8'($urandom));
      if ($urandom_range(4) != 0) send_beat(OP_NACK, 8'($urandom));
    end else begin
      for (i = 0; i < FRAME_BYTES; i++) send_beat(OP_BYTE, 8'($urandom));
    end
  endtask

  // Random frames over several register settings and idling mixes
  task automatic test_random_traffic();
    int phase;
    int start;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        write_conversion(TMP_BIAS_RST, TMP_SPAN_RST, RH_SPAN_RST);
      end else begin
        write_conversion(rand_word(), rand_word(), rand_word());
      end
      gap_pct   = (phase == 2) ? 0 : $urandom_range(10, 60);
      stall_pct = (phase == 2) ? 0 : $urandom_range(10, 60);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) send_random_unit();
    end
  endtask

  // Result sink with random stalls
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready = 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      sink_hold = idle_len() - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%h, actual 0x%h", $time, name, want, got);
    end
  endtask

  // Compare each output beat with the oldest predicted reading
  reading_t want_r;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading: expected none, actual status %0d", $time, status);
      end else begin
        want_r = expected_readings.pop_front();
        report_field("status", 16'(want_r.status), 16'(status));
        report_field("raw_temp", want_r.raw_temp, raw_temp);
        report_field("raw_hum", want_r.raw_hum, raw_hum);
        report_field("temp_hundredths", want_r.temp_h, temp_hundredths);
        report_field("hum_hundredths", want_r.hum_h, hum_hundredths);
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_frame_events();
    test_conversion_extremes();
    test_random_traffic();
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sensor_frame_crc_check_convert_test: PASS");
    end else begin
      $display("sensor_frame_crc_check_convert_test: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("sensor_frame_crc_check_convert_test: FAIL");
    $finish;
  end

endmodule
